@@ rtl/qnp_pkg.sv @@
package qnp_pkg;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic        record_kind;
		logic        accepted;
		logic [7:0]  protocol;
		logic [31:0] ip_source;
		logic [31:0] ip_dest;
		logic [15:0] port_source;
		logic [15:0] port_dest;
		logic [15:0] frame_length;
		logic        dns_query;
		logic [7:0]  name_char;
		logic        last_result;
	} record_t;

	typedef enum logic [2:0] {
		PH_LEN   = 3'b001,
		PH_LABEL = 3'b010,
		PH_DONE  = 3'b100
	} name_phase_t;

	typedef struct packed {
		name_phase_t phase;
		logic        failed;
	} name_stat_t;

	localparam logic        KIND_SUMMARY  = 1'b0;
	localparam logic        KIND_CHAR     = 1'b1;

	localparam logic [15:0] OFF_ETYPE_HI  = 16'd12;
	localparam logic [15:0] OFF_ETYPE_LO  = 16'd13;
	localparam logic [15:0] OFF_VER_IHL   = 16'd14;
	localparam logic [15:0] OFF_PROTO     = 16'd23;
	localparam logic [15:0] OFF_SRC_FIRST = 16'd26;
	localparam logic [15:0] OFF_SRC_LAST  = 16'd29;
	localparam logic [15:0] OFF_DST_FIRST = 16'd30;
	localparam logic [15:0] OFF_DST_LAST  = 16'd33;
	localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
	localparam logic [15:0] MIN_FRAME     = 16'd34;
	localparam logic [15:0] PORT_BYTES    = 16'd4;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
	localparam logic [15:0] DNS_HDR_BYTES = 16'd12;
	localparam logic [15:0] DNS_FLAGS_OFF = 16'd2;
	localparam logic [15:0] DNS_QD_OFF    = 16'd4;
	localparam logic [15:0] BYTE_CNT_MAX  = 16'hFFFF;

	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VERSION    = 4'd4;
	localparam logic [3:0]  MIN_IHL       = 4'd5;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [15:0] DNS_PORT      = 16'd53;
	localparam logic [7:0]  QR_MASK       = 8'h80;
	localparam logic [7:0]  PTR_MASK      = 8'hC0;
	localparam logic [7:0]  CHAR_DOT      = 8'h2E;

endpackage

@@ rtl/qnp_name_store.sv @@
module qnp_name_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/qnp_name_walker.sv @@
module qnp_name_walker #(
	parameter int QNAME_BYTES = 64,
	parameter int NLW         = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                en,
	input  logic [7:0]          data,
	output logic                wr_en,
	output logic [NLW-1:0]      wr_addr,
	output logic [7:0]          wr_data,
	output qnp_pkg::name_stat_t stat,
	output logic [NLW-1:0]      length
);
	import qnp_pkg::*;

	localparam logic [7:0] LEN_LIMIT = 8'(QNAME_BYTES - 1);

	name_phase_t    phase_q;
	logic           failed_q;
	logic [5:0]     rem_q;
	logic [NLW-1:0] len_q;
	logic [7:0]     need;
	logic [7:0]     dot_pos;
	logic           active;
	logic           len_ok;

	assign active  = en && !failed_q && (phase_q != PH_DONE);
	assign need    = 8'(len_q) + {2'b00, data[5:0]} + 8'd1;
	assign dot_pos = 8'(len_q) + {2'b00, data[5:0]};
	assign len_ok  = (data != 8'd0) && ((data & PTR_MASK) == 8'd0) && (need <= LEN_LIMIT);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = len_q;
		wr_data = data;
		if (active) begin
			case (phase_q)
				PH_LEN: begin
					wr_en   = len_ok;
					wr_addr = dot_pos[NLW-1:0];
					wr_data = CHAR_DOT;
				end
				PH_LABEL: begin
					wr_en = 1'b1;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			failed_q <= 1'b0;
			rem_q    <= '0;
			len_q    <= '0;
		end else if (clr) begin
			phase_q  <= PH_LEN;
			failed_q <= 1'b0;
			rem_q    <= '0;
			len_q    <= '0;
		end else if (active) begin
			case (phase_q)
				PH_LEN: begin
					if (data == 8'd0) begin
						phase_q <= PH_DONE;
					end else if (!len_ok) begin
						failed_q <= 1'b1;
					end else begin
						rem_q   <= data[5:0];
						phase_q <= PH_LABEL;
					end
				end
				PH_LABEL: begin
					rem_q <= rem_q - 6'd1;
					if (rem_q == 6'd1) begin
						len_q   <= len_q + NLW'(2);
						phase_q <= PH_LEN;
					end else begin
						len_q <= len_q + NLW'(1);
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end

	assign stat.phase  = phase_q;
	assign stat.failed = failed_q;
	assign length      = len_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		8'(len_q) <= LEN_LIMIT)
		else $error("name length past store");

	a_label_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LABEL) |-> (rem_q != 6'd0))
		else $error("label phase with no bytes left");

	a_no_write_failed: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!failed_q && phase_q != PH_DONE))
		else $error("name write after fail or end");

endmodule

@@ rtl/ipv4_flow_dns_qname_parser_core.sv @@
// Ethernet/IPv4 TCP-UDP header parser with DNS query name extraction.
//
// frame channel: one frame byte per word with a last-byte flag, starting at
// the destination MAC. Header bytes are taken at one word per cycle while frame_stall is low.
// record channel: after the last byte, one summary word (addresses, ports,
// protocol, length, accept and DNS flags), then for a DNS query to UDP port
// 53 one word per name character, dots between labels. last_result marks the
// final word of each frame.
// After the last byte is taken the core moves to the summary state, and the
// summary word is then loaded into the output register. Each name character
// is read from the name memory and then loaded into the output register.
// frame_stall is held high from the last byte until the final word of the
// frame is loaded into the output register.
// Reset clears all header state and the name parser; the name memory keeps
// its contents and only entries written in the current frame are read.
// While the receiver stalls, the output word holds and readout pauses.
module ipv4_flow_dns_qname_parser_core #(
	parameter int QNAME_BYTES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  qnp_pkg::frame_t  frame,
	input  logic             frame_valid,
	output logic             frame_stall,
	output qnp_pkg::record_t record,
	output logic             record_valid,
	input  logic             record_stall
);
	import qnp_pkg::*;

	localparam int NLW = $clog2(QNAME_BYTES);

	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_SUM  = 4'b0010,
		ST_NRD  = 4'b0100,
		ST_NOUT = 4'b1000
	} state_t;

	state_t         state_q;
	logic [15:0]    byte_count_q;
	logic [15:0]    ether_type_q;
	logic [7:0]     ver_ihl_q;
	logic [7:0]     proto_q;
	logic [31:0]    ip_source_q;
	logic [31:0]    ip_dest_q;
	logic [15:0]    port_source_q;
	logic [15:0]    port_dest_q;
	logic [7:0]     dns_flags_q;
	logic [15:0]    qd_count_q;
	logic [NLW-1:0] rd_ptr_q;
	record_t        out_q;
	logic           out_valid_q;

	logic           frame_acc;
	logic           out_free;
	logic           out_load;
	logic           clr;
	logic [3:0]     ihl;
	logic [15:0]    t_off;
	logic [15:0]    d_off;
	logic [15:0]    idx;
	logic           xport_ok;
	logic           name_en;
	logic           acc;
	logic           dns;
	logic           sum_last;
	logic           char_last;
	logic           wr_en;
	logic [NLW-1:0] wr_addr;
	logic [7:0]     wr_data;
	logic           rd_en;
	logic [7:0]     rd_data;
	name_stat_t     stat;
	logic [NLW-1:0] name_len;

	assign frame_stall = (state_q != ST_RUN);
	assign frame_acc   = frame_valid && !frame_stall;
	assign out_free    = !out_valid_q || !record_stall;
	assign out_load    = ((state_q == ST_SUM) || (state_q == ST_NOUT)) && out_free;

	assign idx      = byte_count_q;
	assign ihl      = ver_ihl_q[3:0];
	assign t_off    = ETH_HDR_BYTES + {10'd0, ihl, 2'b00};
	assign d_off    = t_off + UDP_HDR_BYTES;
	assign xport_ok = (idx > OFF_VER_IHL) && (ihl >= MIN_IHL);
	assign name_en  = frame_acc && xport_ok && (idx >= d_off + DNS_HDR_BYTES);

	assign acc = (byte_count_q >= MIN_FRAME) && (ether_type_q == ETH_TYPE_IPV4)
		&& (ver_ihl_q[7:4] == IP_VERSION) && (ihl >= MIN_IHL)
		&& (byte_count_q >= t_off + PORT_BYTES)
		&& ((proto_q == PROTO_TCP) || (proto_q == PROTO_UDP));
	assign dns = acc && (proto_q == PROTO_UDP) && (port_dest_q == DNS_PORT)
		&& (qd_count_q != 16'd0) && ((dns_flags_q & QR_MASK) == 8'd0)
		&& !stat.failed && (stat.phase == PH_DONE) && (name_len != '0);
	assign sum_last  = !dns || (name_len == NLW'(1));
	assign char_last = ({1'b0, rd_ptr_q} + (NLW+1)'(2)) == {1'b0, name_len};

	assign rd_en = (state_q == ST_NRD);
	assign clr   = ((state_q == ST_SUM) && out_free && sum_last)
		|| ((state_q == ST_NOUT) && out_free && char_last);

	qnp_name_walker #(
		.QNAME_BYTES(QNAME_BYTES),
		.NLW        (NLW)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.en     (name_en),
		.data   (frame.frame_byte),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.stat   (stat),
		.length (name_len)
	);

	qnp_name_store #(
		.DEPTH(QNAME_BYTES),
		.AW   (NLW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_ptr_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			ether_type_q  <= '0;
			ver_ihl_q     <= '0;
			proto_q       <= '0;
			ip_source_q   <= '0;
			ip_dest_q     <= '0;
			port_source_q <= '0;
			port_dest_q   <= '0;
			dns_flags_q   <= '0;
			qd_count_q    <= '0;
		end else if (clr) begin
			byte_count_q  <= '0;
			ether_type_q  <= '0;
			ver_ihl_q     <= '0;
			proto_q       <= '0;
			ip_source_q   <= '0;
			ip_dest_q     <= '0;
			port_source_q <= '0;
			port_dest_q   <= '0;
			dns_flags_q   <= '0;
			qd_count_q    <= '0;
		end else if (frame_acc) begin
			if (idx == OFF_ETYPE_HI) begin
				ether_type_q <= {frame.frame_byte, 8'd0};
			end else if (idx == OFF_ETYPE_LO) begin
				ether_type_q <= {ether_type_q[15:8], frame.frame_byte};
			end else if (idx == OFF_VER_IHL) begin
				ver_ihl_q <= frame.frame_byte;
			end else if (idx == OFF_PROTO) begin
				proto_q <= frame.frame_byte;
			end else if (idx >= OFF_SRC_FIRST && idx <= OFF_SRC_LAST) begin
				ip_source_q <= {ip_source_q[23:0], frame.frame_byte};
			end else if (idx >= OFF_DST_FIRST && idx <= OFF_DST_LAST) begin
				ip_dest_q <= {ip_dest_q[23:0], frame.frame_byte};
			end
			if (xport_ok) begin
				if (idx == t_off || idx == t_off + 16'd1) begin
					port_source_q <= {port_source_q[7:0], frame.frame_byte};
				end else if (idx == t_off + 16'd2 || idx == t_off + 16'd3) begin
					port_dest_q <= {port_dest_q[7:0], frame.frame_byte};
				end else if (idx == d_off + DNS_FLAGS_OFF) begin
					dns_flags_q <= frame.frame_byte;
				end else if (idx == d_off + DNS_QD_OFF
					|| idx == d_off + DNS_QD_OFF + 16'd1) begin
					qd_count_q <= {qd_count_q[7:0], frame.frame_byte};
				end
			end
			if (byte_count_q != BYTE_CNT_MAX) begin
				byte_count_q <= byte_count_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && record_stall);
			case (state_q)
				ST_RUN: begin
					rd_ptr_q <= '0;
					if (frame_acc && frame.last_byte) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= sum_last ? ST_RUN : ST_NRD;
					end
				end
				ST_NRD: begin
					state_q <= ST_NOUT;
				end
				ST_NOUT: begin
					if (out_free) begin
						rd_ptr_q <= rd_ptr_q + NLW'(1);
						state_q  <= char_last ? ST_RUN : ST_NRD;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM && out_free) begin
			out_q.record_kind  <= KIND_SUMMARY;
			out_q.accepted     <= acc;
			out_q.protocol     <= acc ? proto_q : 8'd0;
			out_q.ip_source    <= acc ? ip_source_q : 32'd0;
			out_q.ip_dest      <= acc ? ip_dest_q : 32'd0;
			out_q.port_source  <= acc ? port_source_q : 16'd0;
			out_q.port_dest    <= acc ? port_dest_q : 16'd0;
			out_q.frame_length <= byte_count_q;
			out_q.dns_query    <= dns;
			out_q.name_char    <= 8'd0;
			out_q.last_result  <= sum_last;
		end else if (state_q == ST_NOUT && out_free) begin
			out_q.record_kind  <= KIND_CHAR;
			out_q.accepted     <= 1'b0;
			out_q.protocol     <= 8'd0;
			out_q.ip_source    <= 32'd0;
			out_q.ip_dest      <= 32'd0;
			out_q.port_source  <= 16'd0;
			out_q.port_dest    <= 16'd0;
			out_q.frame_length <= 16'd0;
			out_q.dns_query    <= 1'b0;
			out_q.name_char    <= rd_data;
			out_q.last_result  <= char_last;
		end
	end

	assign record       = out_q;
	assign record_valid = out_valid_q;

	a_readout_name_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NRD) |-> (stat.phase == PH_DONE && !stat.failed))
		else $error("name readout without a complete name");

	a_dns_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(record_valid && record.record_kind == KIND_SUMMARY && record.dns_query)
		|-> (record.accepted && record.protocol == PROTO_UDP
			&& record.port_dest == DNS_PORT && !record.last_result))
		else $error("dns summary fields inconsistent");

	a_clear_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (state_q == ST_RUN && byte_count_q == 16'd0))
		else $error("frame state not cleared after last word");

endmodule
